### hw/rtl/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned TAG_W      = 16;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OUT_DATA_W = TAG_W + LEN_W + BYTE_W + LEN_W;
    localparam int unsigned OUT_USER_W = 3;

    // header byte counter codes
    localparam logic [2:0] HDR_TAG_HI = 3'd0;
    localparam logic [2:0] HDR_TAG_LO = 3'd1;
    localparam logic [2:0] HDR_LEN_LO = 3'd5;
    localparam logic [2:0] HDR_DONE   = 3'd6;
    localparam logic [31:0] HDR_BYTES = 32'd6;

    localparam int unsigned USR_IS_VALUE  = 0;
    localparam int unsigned USR_FIELD_END = 1;
    localparam int unsigned USR_TRUNCATED = 2;

endpackage

`default_nettype wire

### hw/rtl/tlv_stream_parser.sv
`default_nettype none

// Byte-serial parser for big-endian TLV records (16-bit tag, 32-bit length,
// value bytes). Each request on the s_ side carries one byte and yields exactly
// one registered request on the m_ side; a new byte is taken every cycle
// while the output register is empty or being drained. Writing cfg_wr_data
// sets the buffer length and restarts parsing. Truncation (short header or a
// declared length beyond the buffer or beyond LENGTH_WIDTH bits) is sticky
// until the next write; bytes past the buffer end give an all-zero result.
module tlv_stream_parser #(
    parameter int unsigned LENGTH_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tsp_pkg::LEN_W-1:0]       cfg_wr_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tsp_pkg::IN_DATA_W-1:0]   s_tdata,   // data_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_tag, out_length, out_byte, out_offset
    output logic [tsp_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [tsp_pkg::OUT_USER_W-1:0]       m_tuser,   // is_value, field_end, truncated
    output logic                                 m_tlast    // buffer_end
);
    import tsp_pkg::*;

    localparam logic [LEN_W-1:0] LenMax = LEN_W'((64'd1 << LENGTH_WIDTH) - 64'd1);

    logic [LEN_W-1:0]      buf_len_reg;
    logic [LEN_W-1:0]      byte_pos_reg, byte_pos_next;
    logic [2:0]            hdr_cnt_reg, hdr_cnt_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      val_idx_reg, val_idx_next;
    logic                  err_reg, err_next;
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [OUT_USER_W-1:0] m_user_reg, m_user_next;
    logic                  m_last_reg, m_last_next;

    logic             accept;
    logic             past_end;
    logic [LEN_W-1:0] remaining;
    logic [LEN_W-1:0] shifted_len;
    logic [LEN_W-1:0] idx_inc;
    logic [BYTE_W-1:0] o_byte;
    logic [LEN_W-1:0] o_off;
    logic             is_val, f_end, trunc;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign past_end    = byte_pos_reg >= buf_len_reg;
    assign remaining   = buf_len_reg - byte_pos_reg;
    assign shifted_len = {len_reg[LEN_W-BYTE_W-1:0], s_tdata};
    assign idx_inc     = val_idx_reg + 1'b1;

    always_comb begin
        byte_pos_next = byte_pos_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        tag_next      = tag_reg;
        len_next      = len_reg;
        val_idx_next  = val_idx_reg;
        err_next      = err_reg;
        o_byte        = '0;
        o_off         = '0;
        is_val        = 1'b0;
        f_end         = 1'b0;
        trunc         = 1'b0;
        if (!past_end) begin
            byte_pos_next = byte_pos_reg + 1'b1;
            if (err_reg) begin
                trunc = 1'b1;
            end else if (hdr_cnt_reg >= HDR_DONE) begin
                is_val       = 1'b1;
                o_byte       = s_tdata;
                o_off        = val_idx_reg;
                val_idx_next = idx_inc;
                if (idx_inc >= len_reg) begin
                    f_end        = 1'b1;
                    hdr_cnt_next = HDR_TAG_HI;
                end
            end else if (hdr_cnt_reg == HDR_TAG_HI) begin
                tag_next     = '0;
                len_next     = '0;
                val_idx_next = '0;
                if (remaining < HDR_BYTES) begin
                    err_next = 1'b1;
                    trunc    = 1'b1;
                end else begin
                    tag_next     = {s_tdata, 8'd0};
                    hdr_cnt_next = HDR_TAG_LO;
                end
            end else if (hdr_cnt_reg == HDR_TAG_LO) begin
                tag_next     = {tag_reg[TAG_W-1:8], s_tdata};
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
            end else begin
                len_next     = shifted_len;
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                if (hdr_cnt_reg == HDR_LEN_LO) begin
                    // bytes left after this one is remaining - 1
                    if (shifted_len > LenMax || shifted_len >= remaining) begin
                        err_next     = 1'b1;
                        trunc        = 1'b1;
                        hdr_cnt_next = HDR_TAG_HI;
                    end else if (shifted_len == '0) begin
                        f_end        = 1'b1;
                        hdr_cnt_next = HDR_TAG_HI;
                    end
                end
            end
            m_data_next = {o_off, o_byte, len_next, tag_next};
            m_last_next = remaining == 32'd1;
        end else begin
            m_data_next = '0;
            m_last_next = 1'b0;
        end
        m_user_next                = '0;
        m_user_next[USR_IS_VALUE]  = is_val;
        m_user_next[USR_FIELD_END] = f_end;
        m_user_next[USR_TRUNCATED] = trunc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_len_reg  <= '0;
            byte_pos_reg <= '0;
            hdr_cnt_reg  <= HDR_TAG_HI;
            tag_reg      <= '0;
            len_reg      <= '0;
            val_idx_reg  <= '0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                buf_len_reg  <= cfg_wr_data;
                byte_pos_reg <= '0;
                hdr_cnt_reg  <= HDR_TAG_HI;
                tag_reg      <= '0;
                len_reg      <= '0;
                val_idx_reg  <= '0;
                err_reg      <= 1'b0;
            end else if (accept) begin
                byte_pos_reg <= byte_pos_next;
                hdr_cnt_reg  <= hdr_cnt_next;
                tag_reg      <= tag_next;
                len_reg      <= len_next;
                val_idx_reg  <= val_idx_next;
                err_reg      <= err_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
            m_last_reg <= m_last_next;
        end
    end

endmodule

`default_nettype wire
